// File: src/nct_pkg.sv
`timescale 1ns / 1ps
package nct_pkg;
  localparam int TRACK_SLOTS_DEF = 32;
  localparam logic [11:0] MATCH_DIST_RST = 12'd50;
  localparam logic [7:0] LOST_LIMIT_RST = 8'd5;

  localparam logic CMD_DET = 1'b0;
  localparam logic CMD_EOF = 1'b1;

  localparam logic [2:0] ST_MATCHED = 3'd0;
  localparam logic [2:0] ST_NEW = 3'd1;
  localparam logic [2:0] ST_DROPPED = 3'd2;
  localparam logic [2:0] ST_REPORT = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  localparam logic REG_MATCH_DIST = 1'b0;
  localparam logic REG_LOST_LIMIT = 1'b1;

  // one queued word between front and back; doubled centers reach 3*4095
  typedef struct packed {
    logic cmd;
    logic [11:0] box_x;
    logic [11:0] box_y;
    logic [11:0] box_w;
    logic [11:0] box_h;
    logic [7:0] class_id;
    logic [13:0] cx;
    logic [13:0] cy;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN, S_DECIDE, S_AGE, S_PURGE_RD, S_PURGE_CHK,
    S_MOVE, S_REPORT_RD, S_REPORT
  } bk_state_e;
endpackage

// File: src/nct_front.sv
`timescale 1ns / 1ps
module nct_front import nct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cmd_i,
  input  logic [11:0] box_x_i,
  input  logic [11:0] box_y_i,
  input  logic [11:0] box_w_i,
  input  logic [11:0] box_h_i,
  input  logic [7:0]  class_id_i,
  output logic        job_valid_o,
  output job_t        job_o,
  input  logic        job_take_i
);
  // two-entry queue; busy when full
  job_t       q_mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  job_t       job_in;

  always_comb begin
    job_in.cmd = cmd_i;
    job_in.box_x = box_x_i;
    job_in.box_y = box_y_i;
    job_in.box_w = box_w_i;
    job_in.box_h = box_h_i;
    job_in.class_id = class_id_i;
    job_in.cx = {1'b0, box_x_i, 1'b0} + {2'b00, box_w_i};
    job_in.cy = {1'b0, box_y_i, 1'b0} + {2'b00, box_h_i};
  end

  assign busy_o = cnt_q[1];
  assign push = start_i && !busy_o;
  assign job_valid_o = cnt_q != 2'd0;
  assign pop = job_valid_o && job_take_i;
  assign job_o = q_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= job_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: src/nct_back.sv
`timescale 1ns / 1ps
module nct_back import nct_pkg::*; #(
  parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_take_o,
  input  logic [11:0] match_distance_i,
  input  logic [7:0]  lost_limit_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [15:0] track_id_o,
  output logic [11:0] out_x_o,
  output logic [11:0] out_y_o,
  output logic [11:0] out_w_o,
  output logic [11:0] out_h_o,
  output logic [7:0]  out_class_o,
  output logic [7:0]  lost_count_o,
  output logic        last_o
);
  localparam int IW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int CW = $clog2(TRACK_SLOTS + 1);
  localparam int RW = 16 + 48 + 28 + 8 + 8;

  // slot record: id, box, center, lost, class
  logic [RW-1:0] mem [TRACK_SLOTS];
  logic [RW-1:0] rd_data_q;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [RW-1:0] wr_data;
  logic [TRACK_SLOTS-1:0] upd_q, upd_d;

  bk_state_e state_q, state_d;
  job_t      job_q, job_d;
  logic [CW-1:0] live_q, live_d, j_q, j_d;
  logic [15:0] idc_q, idc_d;
  logic [28:0] best_q, best_d;
  logic [IW-1:0] bslot_q, bslot_d;
  logic found_q, found_d;

  logic [15:0] r_id;
  logic [13:0] r_cx, r_cy;
  logic [7:0]  r_lost;
  logic [13:0] dx, dy;
  logic [27:0] dxx, dyy;
  logic [28:0] d2;
  logic [23:0] thr;

  logic        res_v_d, res_v_q, res_last_d, res_last_q;
  logic [2:0]  res_st_d, res_st_q;
  logic [RW-1:0] res_rec_d, res_rec_q;

  // id of the matched slot, fetched during the scan
  logic [15:0] mem_id_hold, hold_q;
  logic        age_ph_q;
  assign mem_id_hold = hold_q;

  assign r_id = rd_data_q[RW-1 -: 16];
  assign r_cx = rd_data_q[43:30];
  assign r_cy = rd_data_q[29:16];
  assign r_lost = rd_data_q[15:8];
  assign dx = (job_q.cx >= r_cx) ? job_q.cx - r_cx : r_cx - job_q.cx;
  assign dy = (job_q.cy >= r_cy) ? job_q.cy - r_cy : r_cy - job_q.cy;
  assign dxx = {14'd0, dx} * {14'd0, dx};
  assign dyy = {14'd0, dy} * {14'd0, dy};
  assign d2 = {1'b0, dxx} + {1'b0, dyy};
  assign thr = {12'd0, match_distance_i} * {12'd0, match_distance_i};

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (job_valid_i) state_d = (job_i.cmd == CMD_EOF) ? S_AGE : S_SCAN_RD;
      S_SCAN_RD: state_d = (j_q < live_q) ? S_SCAN : S_DECIDE;
      S_SCAN: state_d = S_SCAN_RD;
      S_DECIDE: state_d = S_IDLE;
      S_AGE: state_d = (j_q < live_q) ? S_AGE : S_PURGE_RD;
      S_PURGE_RD: state_d = (j_q < live_q) ? S_PURGE_CHK : S_REPORT_RD;
      S_PURGE_CHK: state_d = S_PURGE_RD;
      S_MOVE: state_d = S_PURGE_RD;
      S_REPORT_RD: state_d = (live_q == '0) ? S_IDLE : S_REPORT;
      S_REPORT: state_d = (j_q < live_q) ? S_REPORT : S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_PURGE_CHK && r_lost > lost_limit_i) state_d = S_MOVE;
  end

  always_comb begin
    job_d = job_q; live_d = live_q; j_d = j_q; idc_d = idc_q;
    best_d = best_q; bslot_d = bslot_q; found_d = found_q; upd_d = upd_q;
    job_take_o = 1'b0; wr_en = 1'b0; wr_addr = j_q[IW-1:0]; wr_data = rd_data_q;
    rd_addr = j_q[IW-1:0];
    res_v_d = 1'b0; res_last_d = 1'b1; res_st_d = ST_MATCHED; res_rec_d = rd_data_q;
    unique case (state_q)
      S_IDLE: begin
        j_d = '0;
        if (job_valid_i) begin
          job_take_o = 1'b1; job_d = job_i;
          best_d = {3'b000, thr, 2'b00}; found_d = 1'b0; bslot_d = '0;
        end
      end
      S_SCAN_RD: begin
        j_d = j_q + CW'(1);
      end
      S_SCAN: begin
        if (d2 < best_q) begin
          best_d = d2; bslot_d = IW'(j_q - CW'(1)); found_d = 1'b1;
        end
      end
      S_DECIDE: begin
        res_v_d = 1'b1;
        wr_data = {16'd0, job_q.box_x, job_q.box_y, job_q.box_w, job_q.box_h,
                   job_q.cx, job_q.cy, 8'd0, job_q.class_id};
        if (found_q) begin
          wr_en = 1'b1; wr_addr = bslot_q;
          upd_d[bslot_q] = 1'b1;
          wr_data[RW-1 -: 16] = mem_id_hold;
          res_st_d = ST_MATCHED;
        end else if (live_q < CW'(TRACK_SLOTS)) begin
          wr_en = 1'b1; wr_addr = live_q[IW-1:0];
          wr_data[RW-1 -: 16] = idc_q;
          upd_d[live_q[IW-1:0]] = 1'b0;
          idc_d = idc_q + 16'd1; live_d = live_q + CW'(1);
          res_st_d = ST_NEW;
        end else begin
          wr_data = '0; res_st_d = ST_DROPPED;
        end
        res_rec_d = wr_data;
      end
      S_AGE: begin
        // read-modify-write, a read phase then a write phase per slot: read ahead
        rd_addr = j_q[IW-1:0];
        if (age_ph_q) begin
          wr_en = 1'b1; wr_addr = IW'(j_q);
          wr_data = rd_data_q;
          if (!upd_q[j_q[IW-1:0]] && r_lost != 8'hFF) wr_data[15:8] = r_lost + 8'd1;
          j_d = j_q + CW'(1);
        end
        if (j_q >= live_q) j_d = '0;
      end
      S_PURGE_RD: rd_addr = j_q[IW-1:0];
      S_PURGE_CHK: begin
        rd_addr = IW'(live_q - CW'(1));
        if (!(r_lost > lost_limit_i)) j_d = j_q + CW'(1);
      end
      S_MOVE: begin
        wr_en = 1'b1; wr_addr = j_q[IW-1:0]; wr_data = rd_data_q;
        live_d = live_q - CW'(1);
      end
      S_REPORT_RD: begin
        upd_d = '0; j_d = '0; rd_addr = '0;
        if (live_q == '0) begin
          res_v_d = 1'b1; res_st_d = ST_EMPTY; res_rec_d = '0;
        end else begin
          j_d = CW'(1); rd_addr = '0;
        end
      end
      S_REPORT: begin
        rd_addr = j_q[IW-1:0];
        res_v_d = 1'b1; res_st_d = ST_REPORT; res_rec_d = rd_data_q;
        res_last_d = (j_q == live_q);
        j_d = j_q + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; live_q <= '0; j_q <= '0; idc_q <= '0; found_q <= 1'b0;
      upd_q <= '0; res_v_q <= 1'b0; age_ph_q <= 1'b0;
    end else begin
      state_q <= state_d; live_q <= live_d; j_q <= j_d; idc_q <= idc_d;
      found_q <= found_d; upd_q <= upd_d; res_v_q <= res_v_d;
      age_ph_q <= (state_q == S_AGE) ? ~age_ph_q : 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d; best_q <= best_d; bslot_q <= bslot_d;
    if (state_q == S_SCAN && d2 < best_q) hold_q <= r_id;
    res_st_q <= res_st_d; res_rec_q <= res_rec_d; res_last_q <= res_last_d;
  end

  assign result_valid_o = res_v_q;
  assign status_o = res_st_q;
  assign last_o = res_last_q;
  assign track_id_o = res_rec_q[RW-1 -: 16];
  assign out_x_o = res_rec_q[RW-17 -: 12];
  assign out_y_o = res_rec_q[RW-29 -: 12];
  assign out_w_o = res_rec_q[RW-41 -: 12];
  assign out_h_o = res_rec_q[RW-53 -: 12];
  assign out_class_o = res_rec_q[7:0];
  assign lost_count_o = res_rec_q[15:8];
endmodule

// File: src/nearest_centroid_tracker_core.sv
`timescale 1ns / 1ps
// channel | ports                                       | dir
// command | start_i, busy_o, cmd_i, box_*_i, class_id_i | in
// result  | result_valid_o + status_o .. last_o         | out
// config  | cfg_we_i, cfg_idx_i, cfg_wdata_i            | in
// Detection: each live slot is read and its distance compared, then a decision
// writes the slot; the result word is registered.
// End of frame: aging of every live slot, a purge that moves the last slot into
// each removed one, then one report word a cycle.
// A two-word command queue decouples intake; busy_o rises when it is full.
// Results are one-cycle strobes; the receiver cannot stall. Reset is async.
module nearest_centroid_tracker_core import nct_pkg::*; #(
  parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cmd_i,
  input  logic [11:0] box_x_i,
  input  logic [11:0] box_y_i,
  input  logic [11:0] box_w_i,
  input  logic [11:0] box_h_i,
  input  logic [7:0]  class_id_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [15:0] track_id_o,
  output logic [11:0] out_x_o,
  output logic [11:0] out_y_o,
  output logic [11:0] out_w_o,
  output logic [11:0] out_h_o,
  output logic [7:0]  out_class_o,
  output logic [7:0]  lost_count_o,
  output logic        last_o
);
  logic [11:0] md_q;
  logic [7:0]  ll_q;
  logic        jv, jt;
  job_t        job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q <= MATCH_DIST_RST;
      ll_q <= LOST_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MATCH_DIST: md_q <= cfg_wdata_i;
        REG_LOST_LIMIT: ll_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  nct_front u_front (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .box_x_i, .box_y_i, .box_w_i,
    .box_h_i, .class_id_i, .job_valid_o(jv), .job_o(job), .job_take_i(jt)
  );

  nct_back #(.TRACK_SLOTS(TRACK_SLOTS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(jv), .job_i(job), .job_take_o(jt),
    .match_distance_i(md_q), .lost_limit_i(ll_q), .result_valid_o, .status_o,
    .track_id_o, .out_x_o, .out_y_o, .out_w_o, .out_h_o, .out_class_o,
    .lost_count_o, .last_o
  );
endmodule

// File: tb/tb_nearest_centroid_tracker_core.sv
`timescale 1ns / 1ps
module tb_nearest_centroid_tracker_core;
  import nct_pkg::*;

  localparam int SLOTS = 32;
  localparam int STALL_LIMIT = 4000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        cmd_i;
  logic [11:0] box_x_i, box_y_i, box_w_i, box_h_i;
  logic [7:0]  class_id_i;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [11:0] cfg_wdata_i;
  logic        result_valid_o;
  logic [2:0]  status_o;
  logic [15:0] track_id_o;
  logic [11:0] out_x_o, out_y_o, out_w_o, out_h_o;
  logic [7:0]  out_class_o;
  logic [7:0]  lost_count_o;
  logic        last_o;

  nearest_centroid_tracker_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .box_x_i, .box_y_i, .box_w_i,
    .box_h_i, .class_id_i, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .result_valid_o,
    .status_o, .track_id_o, .out_x_o, .out_y_o, .out_w_o, .out_h_o, .out_class_o,
    .lost_count_o, .last_o
  );

  typedef struct {
    logic [2:0]  status;
    logic [15:0] id;
    logic [11:0] x, y, w, h;
    logic [7:0]  cls;
    logic [7:0]  lost;
    logic        last;
  } track_word_t;

  typedef struct {
    logic        cmd;
    logic [11:0] x, y, w, h;
    logic [7:0]  cls;
    bit          chk;
    logic [2:0]  e_status;
    logic [15:0] e_id;
  } stim_row_t;

  // shadow track table
  logic [15:0] trk_id  [SLOTS];
  logic [11:0] trk_x   [SLOTS];
  logic [11:0] trk_y   [SLOTS];
  logic [11:0] trk_w   [SLOTS];
  logic [11:0] trk_h   [SLOTS];
  logic [13:0] trk_cx  [SLOTS];
  logic [13:0] trk_cy  [SLOTS];
  logic [7:0]  trk_lost[SLOTS];
  logic [7:0]  trk_cls [SLOTS];
  bit          trk_upd [SLOTS];
  int          live;
  logic [15:0] next_id;
  logic [11:0] sh_match_dist;
  logic [7:0]  sh_lost_limit;

  track_word_t pending_words[$];
  int errors;
  int idle_cycles;
  int burst_left;
  bit no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report(string what);
    $display("mismatch @%0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic track_word_t slot_word(logic [2:0] st, int s, logic fin);
    track_word_t t;
    t.status = st; t.id = trk_id[s];
    t.x = trk_x[s]; t.y = trk_y[s]; t.w = trk_w[s]; t.h = trk_h[s];
    t.cls = trk_cls[s]; t.lost = trk_lost[s]; t.last = fin;
    return t;
  endfunction

  function automatic track_word_t blank_word(logic [2:0] st);
    track_word_t t;
    t = '{status: st, id: '0, x: '0, y: '0, w: '0, h: '0, cls: '0, lost: '0, last: 1'b1};
    return t;
  endfunction

  function automatic void write_track(int s, logic [11:0] x, logic [11:0] y,
                                      logic [11:0] w, logic [11:0] h, logic [7:0] c);
    trk_x[s] = x; trk_y[s] = y; trk_w[s] = w; trk_h[s] = h;
    trk_cx[s] = 14'(2 * x + w);
    trk_cy[s] = 14'(2 * y + h);
    trk_lost[s] = '0;
    trk_cls[s] = c;
  endfunction

  // update the shadow table for one accepted word and queue its results
  function automatic void track_update(logic cmd, logic [11:0] x, logic [11:0] y,
                                       logic [11:0] w, logic [11:0] h, logic [7:0] c);
    longint best, d2, dx, dy, cx, cy;
    int pick;
    int j;
    if (cmd == CMD_DET) begin
      cx = 2 * longint'(x) + longint'(w);
      cy = 2 * longint'(y) + longint'(h);
      best = 4 * longint'(sh_match_dist) * longint'(sh_match_dist);
      pick = -1;
      for (j = 0; j < live; j++) begin
        dx = cx - longint'(trk_cx[j]);
        dy = cy - longint'(trk_cy[j]);
        d2 = dx * dx + dy * dy;
        if (d2 < best) begin
          best = d2;
          pick = j;
        end
      end
      if (pick >= 0) begin
        write_track(pick, x, y, w, h, c);
        trk_upd[pick] = 1'b1;
        pending_words.push_back(slot_word(ST_MATCHED, pick, 1'b1));
      end else if (live < SLOTS) begin
        trk_id[live] = next_id;
        next_id++;
        write_track(live, x, y, w, h, c);
        trk_upd[live] = 1'b0;
        pending_words.push_back(slot_word(ST_NEW, live, 1'b1));
        live++;
      end else begin
        pending_words.push_back(blank_word(ST_DROPPED));
      end
      return;
    end
    for (j = 0; j < live; j++)
      if (!trk_upd[j] && trk_lost[j] != 8'hFF) trk_lost[j]++;
    j = 0;
    while (j < live) begin
      if (trk_lost[j] > sh_lost_limit) begin
        live--;
        trk_id[j] = trk_id[live];
        trk_x[j] = trk_x[live]; trk_y[j] = trk_y[live];
        trk_w[j] = trk_w[live]; trk_h[j] = trk_h[live];
        trk_cx[j] = trk_cx[live]; trk_cy[j] = trk_cy[live];
        trk_lost[j] = trk_lost[live];
        trk_cls[j] = trk_cls[live];
      end else begin
        j++;
      end
    end
    for (j = 0; j < SLOTS; j++) trk_upd[j] = 1'b0;
    if (live == 0) pending_words.push_back(blank_word(ST_EMPTY));
    for (j = 0; j < live; j++)
      pending_words.push_back(slot_word(ST_REPORT, j, j == live - 1));
  endfunction

  task automatic pace();
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic send_word(logic cmd, logic [11:0] x, logic [11:0] y,
                           logic [11:0] w, logic [11:0] h, logic [7:0] c);
    pace();
    start_i <= 1'b1;
    cmd_i <= cmd;
    box_x_i <= x; box_y_i <= y; box_w_i <= w; box_h_i <= h;
    class_id_i <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    idle_cycles = 0;
    track_update(cmd, x, y, w, h, c);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [11:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MATCH_DIST) sh_match_dist = val;
    else sh_lost_limit = val[7:0];
  endtask

  function automatic logic [11:0] clip(int v);
    return (v < 0) ? 12'd0 : (v > 4095) ? 12'd4095 : 12'(v);
  endfunction

  // result checker; results cannot be held off
  always @(posedge clk_i) begin
    track_word_t e;
    if (rst_ni && result_valid_o) begin
      idle_cycles = 0;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word status %0d id %0d", status_o, track_id_o));
      end else begin
        e = pending_words.pop_front();
        if (status_o !== e.status) report($sformatf("status %0d exp %0d", status_o, e.status));
        if (track_id_o !== e.id) report($sformatf("track_id %0d exp %0d", track_id_o, e.id));
        if (out_x_o !== e.x) report($sformatf("out_x %0d exp %0d", out_x_o, e.x));
        if (out_y_o !== e.y) report($sformatf("out_y %0d exp %0d", out_y_o, e.y));
        if (out_w_o !== e.w) report($sformatf("out_w %0d exp %0d", out_w_o, e.w));
        if (out_h_o !== e.h) report($sformatf("out_h %0d exp %0d", out_h_o, e.h));
        if (out_class_o !== e.cls) report($sformatf("class %0d exp %0d", out_class_o, e.cls));
        if (lost_count_o !== e.lost) report($sformatf("lost %0d exp %0d", lost_count_o, e.lost));
        if (last_o !== e.last) report($sformatf("last %0d exp %0d", last_o, e.last));
      end
    end
  end

  always @(posedge clk_i) begin
    idle_cycles++;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb_nearest_centroid_tracker_core NOT OK");
      $finish;
    end
  end

  stim_row_t dir_rows[] = '{
    '{CMD_EOF, 0, 0, 0, 0, 0, 1, ST_EMPTY, 0},
    '{CMD_DET, 0, 0, 0, 0, 0, 1, ST_NEW, 0},
    '{CMD_DET, 0, 0, 0, 0, 255, 1, ST_MATCHED, 0},
    '{CMD_DET, 4095, 4095, 4095, 4095, 8'hAA, 1, ST_NEW, 1},
    '{CMD_DET, 4095, 4095, 4095, 4095, 8'h55, 1, ST_MATCHED, 1},
    '{CMD_DET, 10, 10, 0, 0, 3, 1, ST_MATCHED, 0},
    '{CMD_DET, 100, 0, 0, 0, 4, 1, ST_NEW, 2},
    // equidistant from slots 0 and 2: lower slot wins
    '{CMD_DET, 55, 5, 0, 0, 5, 1, ST_MATCHED, 0},
    // exactly at the threshold: no match
    '{CMD_DET, 4095, 4095, 4095, 3995, 6, 1, ST_NEW, 3},
    '{CMD_DET, 4095, 4095, 4095, 3996, 7, 0, 0, 0},
    '{CMD_DET, 2048, 1024, 100, 50, 8, 0, 0, 0},
    '{CMD_EOF, 0, 0, 0, 0, 0, 0, 0, 0},
    '{CMD_DET, 2049, 1025, 101, 51, 9, 0, 0, 0},
    '{CMD_EOF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF, 0, 0, 0},
    '{CMD_EOF, 0, 0, 0, 0, 0, 0, 0, 0},
    '{CMD_EOF, 0, 0, 0, 0, 0, 0, 0, 0},
    '{CMD_EOF, 0, 0, 0, 0, 0, 0, 0, 0},
    '{CMD_EOF, 0, 0, 0, 0, 0, 0, 0, 0},
    '{CMD_EOF, 0, 0, 0, 0, 0, 0, 0, 0},
    '{CMD_EOF, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  initial begin
    logic [11:0] md_set[5];
    logic [11:0] ll_set[5];
    int r, s;
    md_set = '{12'd50, 12'd1, 12'd300, 12'd4095, 12'd2000};
    ll_set = '{12'd5, 12'd0, 12'd3, 12'd254, 12'd1};
    start_i <= 1'b0; cmd_i <= 1'b0;
    box_x_i <= '0; box_y_i <= '0; box_w_i <= '0; box_h_i <= '0; class_id_i <= '0;
    cfg_we_i <= 1'b0; cfg_idx_i <= 1'b0; cfg_wdata_i <= '0;
    rst_ni <= 1'b0;
    errors = 0; idle_cycles = 0; burst_left = 0; no_gaps = 1'b0;
    live = 0; next_id = '0;
    sh_match_dist = MATCH_DIST_RST; sh_lost_limit = LOST_LIMIT_RST;
    for (int j = 0; j < SLOTS; j++) trk_upd[j] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y, dir_rows[i].w,
                dir_rows[i].h, dir_rows[i].cls);
      if (dir_rows[i].chk && (pending_words[$].status !== dir_rows[i].e_status ||
                              pending_words[$].id !== dir_rows[i].e_id))
        report($sformatf("directed row %0d predicted status/id differ", i));
    end

    // zero distance: every detection is new; fill the table and overflow it
    cfg_write(REG_MATCH_DIST, 12'd0);
    cfg_write(REG_LOST_LIMIT, 12'd0);
    repeat (SLOTS + 3)
      send_word(CMD_DET, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                8'($urandom));
    send_word(CMD_EOF, 0, 0, 0, 0, 0);
    send_word(CMD_EOF, 0, 0, 0, 0, 0);

    for (int k = 0; k < 5; k++) begin
      cfg_write(REG_MATCH_DIST, md_set[k]);
      cfg_write(REG_LOST_LIMIT, ll_set[k]);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (23) begin
        r = $urandom_range(0, 99);
        if (r < 14) begin
          send_word(CMD_EOF, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                    8'($urandom));
        end else if (r < 70 && live > 0) begin
          // jitter around a live track so matches and ties happen
          s = $urandom_range(0, live - 1);
          send_word(CMD_DET,
                    clip(int'(trk_x[s]) + $urandom_range(0, sh_match_dist) -
                         sh_match_dist / 2),
                    clip(int'(trk_y[s]) + $urandom_range(0, sh_match_dist) -
                         sh_match_dist / 2),
                    clip(int'(trk_w[s]) + $urandom_range(0, 8) - 4),
                    clip(int'(trk_h[s]) + $urandom_range(0, 8) - 4), 8'($urandom));
        end else begin
          send_word(CMD_DET, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                    8'($urandom));
        end
      end
      send_word(CMD_EOF, 0, 0, 0, 0, 0);
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_words.size() == 0)
      $display("tb_nearest_centroid_tracker_core OK");
    else
      $display("tb_nearest_centroid_tracker_core NOT OK");
    $finish;
  end

endmodule
